// File: rtl/u2u8_pkg.sv
// shared constants for the ucs2 string field to utf-8 decoder
package u2u8_pkg;

   // decoder phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LOW  = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;

   // result beats one input beat can cause
   localparam int MaxResults = 4;
   localparam int CntW       = $clog2(MaxResults + 1);
   localparam int IdxW       = $clog2(MaxResults);

   localparam int LenW = 10;

   // utf-8 encoding constants
   localparam logic [15:0] TwoByteMin   = 16'h0080;
   localparam logic [15:0] ThreeByteMin = 16'h0800;
   localparam logic [7:0]  Lead3        = 8'hE0;
   localparam logic [7:0]  Lead2        = 8'hC0;
   localparam logic [7:0]  ContMark     = 8'h80;

endpackage

// File: rtl/ucs2_string_field_to_utf8.sv
// ucs2 little-endian string field to utf-8 decoder, top level
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  req     | in        | req_valid/req_stall  | in_byte, start_field, end_of_data
//  rsp     | out       | rsp_valid/rsp_stall  | out_byte, last_of_run, string_done,
//          |           |                      | truncated, char_count, utf8_length
//
//  a req beat lands in an input register, then combinational decode logic fills a
//  four-entry result buffer once it is free; the buffer drains one rsp beat per cycle unless rsp_stall
//  an input beat yields up to four result beats: a low byte none, a high byte 1 to 3,
//  plus one for a terminator or truncation beat, all through the single rsp port
//  the next input is loaded in the cycle the last result beat is taken
//  reset is synchronous, active high, and returns the decoder to idle
//  with rsp_stall held, the input register holds one beat and then stalls req
module ucs2_string_field_to_utf8 (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_in_byte,
   input  logic                        req_start_field,
   input  logic                        req_end_of_data,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_string_done,
   output logic                        rsp_truncated,
   output logic [7:0]                  rsp_char_count,
   output logic [u2u8_pkg::LenW-1:0]   rsp_utf8_length
);

   localparam int CntW = u2u8_pkg::CntW;
   localparam int IdxW = u2u8_pkg::IdxW;
   localparam int LenW = u2u8_pkg::LenW;
   localparam int NRes = u2u8_pkg::MaxResults;

   // input register
   logic            in_vld_ff, in_vld_in;
   logic [7:0]      in_byte_ff;
   logic            in_start_ff;
   logic            in_eod_ff;

   // decoder state
   logic [1:0]      phase_ff, phase_in;
   logic [7:0]      units_left_ff, units_left_in;
   logic [7:0]      low_half_ff, low_half_in;
   logic [7:0]      unit_total_ff, unit_total_in;
   logic [LenW-1:0] bw_ff, bw_in;

   // result buffer
   logic [7:0]      res_byte_ff [NRes];
   logic [7:0]      res_byte_in [NRes];
   logic [CntW-1:0] n_ff, n_in;
   logic [IdxW-1:0] idx_ff;
   logic            done_ff, done_in;
   logic            trunc_ff, trunc_in;
   logic [7:0]      cc_ff, cc_in;
   logic [LenW-1:0] len_ff, len_in;

   logic            req_take;
   logic            rsp_take;
   logic            buf_free;
   logic            load;
   logic [15:0]     ch;
   logic [1:0]      nb;
   logic [7:0]      units_dec;
   logic            term;

   // handshakes
   assign rsp_valid = (n_ff != '0);
   assign rsp_take  = rsp_valid & ~rsp_stall;
   // buffer frees when empty or when its final beat leaves this cycle
   assign buf_free  = (n_ff == '0) | ((n_ff == CntW'(1)) & rsp_take);
   assign load      = in_vld_ff & buf_free;
   assign req_stall = in_vld_ff & ~load;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (load) begin
         in_vld_in = 1'b0;
      end
   end

   // decode one input beat into up to four result beats
   assign ch        = {in_byte_ff, low_half_ff};
   assign units_dec = units_left_ff - 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      units_left_in = units_left_ff;
      low_half_in   = low_half_ff;
      unit_total_in = unit_total_ff;
      bw_in         = bw_ff;
      for (int i = 0; i < NRes; i++) begin
         res_byte_in[i] = 8'd0;
      end
      nb       = 2'd0;
      term     = 1'b0;
      trunc_in = 1'b0;

      if (in_start_ff) begin
         // count byte, aborts any string in progress
         unit_total_in = in_byte_ff;
         units_left_in = in_byte_ff;
         bw_in         = '0;
         low_half_in   = 8'd0;
         if (in_byte_ff == 8'd0) begin
            term = 1'b1;
         end else begin
            phase_in = u2u8_pkg::PH_LOW;
            trunc_in = in_eod_ff;
         end
      end else begin
         case (phase_ff)
            u2u8_pkg::PH_LOW: begin
               low_half_in = in_byte_ff;
               phase_in    = u2u8_pkg::PH_HIGH;
               trunc_in    = in_eod_ff;
            end
            u2u8_pkg::PH_HIGH: begin
               if (ch >= u2u8_pkg::ThreeByteMin) begin
                  res_byte_in[0] = u2u8_pkg::Lead3 | {4'd0, ch[15:12]};
                  res_byte_in[1] = u2u8_pkg::ContMark | {2'd0, ch[11:6]};
                  res_byte_in[2] = u2u8_pkg::ContMark | {2'd0, ch[5:0]};
                  nb             = 2'd3;
               end else if (ch >= u2u8_pkg::TwoByteMin) begin
                  res_byte_in[0] = u2u8_pkg::Lead2 | {3'd0, ch[10:6]};
                  res_byte_in[1] = u2u8_pkg::ContMark | {2'd0, ch[5:0]};
                  nb             = 2'd2;
               end else begin
                  res_byte_in[0] = ch[7:0];
                  nb             = 2'd1;
               end
               bw_in         = bw_ff + {{(LenW-2){1'b0}}, nb};
               units_left_in = units_dec;
               if (units_dec == 8'd0) begin
                  term = 1'b1;
               end else begin
                  phase_in = u2u8_pkg::PH_LOW;
                  trunc_in = in_eod_ff;
               end
            end
            default: begin
               // idle or unused code: byte ignored
               phase_in = u2u8_pkg::PH_IDLE;
            end
         endcase
      end

      if (term || trunc_in) begin
         phase_in      = u2u8_pkg::PH_IDLE;
         units_left_in = 8'd0;
      end
      done_in = term;
      cc_in   = term ? unit_total_in : 8'd0;
      len_in  = term ? (bw_in + LenW'(1)) : '0;
      n_in    = {1'b0, nb} + CntW'(term | trunc_in);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         phase_ff      <= u2u8_pkg::PH_IDLE;
         units_left_ff <= 8'd0;
         low_half_ff   <= 8'd0;
         unit_total_ff <= 8'd0;
         bw_ff         <= '0;
         n_ff          <= '0;
         idx_ff        <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (load) begin
            phase_ff      <= phase_in;
            units_left_ff <= units_left_in;
            low_half_ff   <= low_half_in;
            unit_total_ff <= unit_total_in;
            bw_ff         <= bw_in;
            n_ff          <= n_in;
            idx_ff        <= '0;
         end else if (rsp_take) begin
            n_ff   <= n_ff - CntW'(1);
            idx_ff <= idx_ff + IdxW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_in_byte;
         in_start_ff <= req_start_field;
         in_eod_ff   <= req_end_of_data;
      end
      if (load) begin
         for (int i = 0; i < NRes; i++) begin
            res_byte_ff[i] <= res_byte_in[i];
         end
         done_ff  <= done_in;
         trunc_ff <= trunc_in;
         cc_ff    <= cc_in;
         len_ff   <= len_in;
      end
   end

   // output beat: status fields ride only on the last beat of a run
   assign rsp_out_byte    = res_byte_ff[idx_ff];
   assign rsp_last_of_run = (n_ff == CntW'(1));
   assign rsp_string_done = rsp_last_of_run & done_ff;
   assign rsp_truncated   = rsp_last_of_run & trunc_ff;
   assign rsp_char_count  = rsp_last_of_run ? cc_ff : 8'd0;
   assign rsp_utf8_length = rsp_last_of_run ? len_ff : '0;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CntW'(NRes))
      else $error("result count exceeds buffer depth");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (load && (n_in != '0)) |=> rsp_valid)
      else $error("loaded results not presented");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_string_done && rsp_truncated))
      else $error("terminator and truncation on one beat");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !load |=> ($stable(phase_ff) && $stable(bw_ff) && $stable(units_left_ff)))
      else $error("decoder state moved without a load");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && (n_ff != '0)))
      else $error("req stalled with room to load");
`endif

endmodule
